>>> hdl/hcn_pkg.sv
// Package for the grey-level histogram with cumulative distribution.
// Holds sizes, operation codes and saturation limits; no dependencies.
package hcn_pkg;

    localparam int LEVELS      = 256;
    localparam int ADDR_BITS   = $clog2(LEVELS);
    localparam int LEVEL_BITS  = 8;
    localparam int COUNT_BITS  = 24;
    localparam int SUM_BITS    = 32;
    localparam int FRAC_BITS   = 17;
    localparam int DIV_STEPS   = FRAC_BITS - 1;
    localparam int DCNT_BITS   = $clog2(DIV_STEPS);

    localparam logic [COUNT_BITS-1:0] BIN_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]   SUM_MAX = {SUM_BITS{1'b1}};
    localparam logic [FRAC_BITS-1:0]  ONE_Q16 = {1'b1, {(FRAC_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_COUNT    = 2'd1,
        OP_CUMULATE = 2'd2,
        OP_READ     = 2'd3
    } t_op;

endpackage

>>> hdl/hcn_if.sv
// Request and result channel interfaces of the histogram unit.
// Depends on hcn_pkg for field widths.
interface hcn_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          operation;
    logic [hcn_pkg::LEVEL_BITS-1:0]      pixel_level;

    modport source (output valid, operation, pixel_level, input ready);
    modport sink   (input valid, operation, pixel_level, output ready);
endinterface

interface hcn_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [hcn_pkg::COUNT_BITS-1:0]      bin_value;
    logic [hcn_pkg::FRAC_BITS-1:0]       bin_fraction;
    logic [hcn_pkg::SUM_BITS-1:0]        total_sum;
    logic                                zero_total;

    modport source (output valid, bin_value, bin_fraction, total_sum, zero_total, input ready);
    modport sink   (input valid, bin_value, bin_fraction, total_sum, zero_total, output ready);
endinterface

>>> hdl/histogram_cumulative_normalize_unit.sv
// Grey-level histogram: bin memory, saturating total, in-place prefix sum
// and a bit-serial divider for the Q1.16 share. Depends on hcn_pkg, hcn_if.
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    operation, pixel_level
//  o_rsp     out  valid/ready    bin_value, bin_fraction, total_sum, zero_total
//
// One request at a time; a clear goes straight to S_OUT, a count through S_CNT,
// a read through S_RD (S_DIV if the 16-step restoring divider runs), a cumulate
// through S_CUM, one bin read and written back per cycle in the single memory.
// Reset and clear zero all bins at once through per-bin valid bits.
// A held result stalls only the hand-off; the next request is taken once
// the previous result sits in the output register.
module histogram_cumulative_normalize_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hcn_req_if.sink   i_req,
    hcn_rsp_if.source o_rsp
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CNT  = 6'b000010,
        S_RD   = 6'b000100,
        S_DIV  = 6'b001000,
        S_CUM  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    localparam int AB = hcn_pkg::ADDR_BITS;
    localparam int CB = hcn_pkg::COUNT_BITS;
    localparam int SB = hcn_pkg::SUM_BITS;
    localparam int FB = hcn_pkg::FRAC_BITS;
    localparam int DB = hcn_pkg::DCNT_BITS;

    t_state r_state;

    logic [CB-1:0] r_mem [hcn_pkg::LEVELS];
    logic [CB-1:0] r_mem_q;
    logic          r_valid [hcn_pkg::LEVELS];
    logic          r_vld_q;

    logic [AB-1:0] r_idx;
    logic [CB-1:0] r_prev;
    logic [SB-1:0] r_total;
    logic [SB-1:0] r_sum;
    logic [CB-1:0] r_res_value;
    logic [FB-1:0] r_res_frac;
    logic [SB-1:0] r_rem;
    logic [FB-2:0] r_quo;
    logic [DB-1:0] r_dcnt;

    logic          r_out_valid;
    logic [CB-1:0] r_out_value;
    logic [FB-1:0] r_out_frac;
    logic [SB-1:0] r_out_sum;
    logic          r_out_zero;

    logic          w_accept;
    logic          w_out_free;
    logic          w_in_range;
    hcn_pkg::t_op  w_op;
    logic [AB-1:0] w_level_addr;
    logic [CB-1:0] w_data;
    logic [CB:0]   w_cum_add;
    logic [CB-1:0] w_cum_val;
    logic [SB:0]   w_tot_add;
    logic [SB-1:0] w_tot_val;
    logic [SB:0]   w_rem2;
    logic          w_ge;
    logic [SB:0]   w_rem_sub;
    logic          w_we;
    logic [AB-1:0] w_waddr;
    logic [CB-1:0] w_wdata;
    logic [AB-1:0] w_raddr;
    logic          w_clear;

    assign w_op         = hcn_pkg::t_op'(i_req.operation);
    assign w_accept     = i_req.valid && i_req.ready;
    assign w_out_free   = !r_out_valid || o_rsp.ready;
    assign w_in_range   = 32'(i_req.pixel_level) < 32'(hcn_pkg::LEVELS);
    assign w_level_addr = AB'(i_req.pixel_level);
    assign w_data       = r_vld_q ? r_mem_q : '0;

    // prefix step and running total, both saturating
    assign w_cum_add = {1'b0, w_data} + {1'b0, r_prev};
    assign w_cum_val = w_cum_add[CB] ? hcn_pkg::BIN_MAX : w_cum_add[CB-1:0];
    assign w_tot_add = {1'b0, r_total} + (SB+1)'(w_cum_val);
    assign w_tot_val = w_tot_add[SB] ? hcn_pkg::SUM_MAX : w_tot_add[SB-1:0];

    // one restoring division step; remainder stays below the total
    assign w_rem2    = {r_rem, 1'b0};
    assign w_ge      = w_rem2 >= {1'b0, r_sum};
    assign w_rem_sub = w_rem2 - {1'b0, r_sum};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_data + CB'(1);
        w_raddr = r_idx;
        w_clear = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_raddr = (w_op == hcn_pkg::OP_CUMULATE) ? '0 : w_level_addr;
                w_clear = w_accept && (w_op == hcn_pkg::OP_CLEAR);
            end
            S_CNT: begin
                w_we = (w_data != hcn_pkg::BIN_MAX);
            end
            S_CUM: begin
                w_we    = 1'b1;
                w_wdata = w_cum_val;
                w_raddr = r_idx + AB'(1);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int k = 0; k < hcn_pkg::LEVELS; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_vld_q <= 1'b0;
        end else begin
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            r_vld_q <= r_valid[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_value <= '0;
                        r_res_frac  <= '0;
                        case (w_op)
                            hcn_pkg::OP_CLEAR: begin
                                r_sum   <= '0;
                                r_state <= S_OUT;
                            end
                            hcn_pkg::OP_COUNT: begin
                                r_idx   <= w_level_addr;
                                r_state <= w_in_range ? S_CNT : S_OUT;
                            end
                            hcn_pkg::OP_CUMULATE: begin
                                r_idx   <= '0;
                                r_prev  <= '0;
                                r_total <= '0;
                                r_state <= S_CUM;
                            end
                            default: begin
                                r_idx   <= w_level_addr;
                                r_state <= w_in_range ? S_RD : S_OUT;
                            end
                        endcase
                    end
                end
                S_CNT: begin
                    if (w_data != hcn_pkg::BIN_MAX && r_sum != hcn_pkg::SUM_MAX) begin
                        r_sum <= r_sum + SB'(1);
                    end
                    r_state <= S_OUT;
                end
                S_RD: begin
                    r_res_value <= w_data;
                    r_rem       <= SB'(w_data);
                    r_quo       <= '0;
                    r_dcnt      <= DB'(hcn_pkg::DIV_STEPS - 1);
                    if (r_sum == '0) begin
                        r_res_frac <= '0;
                        r_state    <= S_OUT;
                    end else if (SB'(w_data) >= r_sum) begin
                        r_res_frac <= hcn_pkg::ONE_Q16;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? w_rem_sub[SB-1:0] : w_rem2[SB-1:0];
                    r_quo  <= {r_quo[FB-3:0], w_ge};
                    r_dcnt <= r_dcnt - DB'(1);
                    if (r_dcnt == '0) begin
                        r_res_frac <= {1'b0, r_quo[FB-3:0], w_ge};
                        r_state    <= S_OUT;
                    end
                end
                S_CUM: begin
                    r_prev  <= w_cum_val;
                    r_total <= w_tot_val;
                    r_idx   <= r_idx + AB'(1);
                    if (r_idx == AB'(hcn_pkg::LEVELS - 1)) begin
                        r_sum   <= w_tot_val;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register: load when the previous result is gone or leaving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
            r_out_value <= r_res_value;
            r_out_frac  <= r_res_frac;
            r_out_sum   <= r_sum;
            r_out_zero  <= (r_sum == '0);
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.bin_value    = r_out_value;
    assign o_rsp.bin_fraction = r_out_frac;
    assign o_rsp.total_sum    = r_out_sum;
    assign o_rsp.zero_total   = r_out_zero;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_sum != '0 && r_rem < r_sum))
        else $error("divider running with bad remainder or zero total");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (o_rsp.valid && r_state == S_IDLE))
        else $error("finished result not loaded into output register");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((o_rsp.zero_total == (o_rsp.total_sum == '0))
                         && o_rsp.bin_fraction <= hcn_pkg::ONE_Q16))
        else $error("zero flag or fraction inconsistent");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for histogram_cumulative_normalize_unit: a directed request
// table, then random traffic, every result checked against its table row or a behavioral histogram.
// Depends on hcn_pkg, the hcn_req_if / hcn_rsp_if interfaces and the unit itself.
module tb;

    localparam int LEVELS         = hcn_pkg::LEVELS;
    localparam int LEVEL_BITS     = hcn_pkg::LEVEL_BITS;
    localparam int COUNT_BITS     = hcn_pkg::COUNT_BITS;
    localparam int FRAC_BITS      = hcn_pkg::FRAC_BITS;
    localparam int SUM_BITS       = hcn_pkg::SUM_BITS;

    localparam int RANDOM_REQS    = 600;
    localparam int HOLD_AT        = 150;
    localparam int DRAIN_AT       = 300;
    localparam int QUIET_AT       = 480;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = LEVELS + 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct packed {
        logic [COUNT_BITS-1:0] bin_value;
        logic [FRAC_BITS-1:0]  bin_fraction;
        logic [SUM_BITS-1:0]   total_sum;
        logic                  zero_total;
    } t_hist_result;

    typedef struct packed {
        hcn_pkg::t_op          op;
        logic [LEVEL_BITS-1:0] level;
        logic                  typed;
        t_hist_result          want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hcn_req_if req_if ();
    hcn_rsp_if rsp_if ();

    histogram_cumulative_normalize_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow histogram: one count per level and the saturated total.
    logic [COUNT_BITS-1:0] hist_bins [LEVELS];
    logic [SUM_BITS-1:0]   hist_total;
    t_hist_result          expected_q [$];
    int                    mismatch_count = 0;
    int                    stall_cycles = 0;
    bit                    hold_ready_low = 1'b0;
    bit                    quiet_tail = 1'b0;

    // Typed rows carry a result that follows directly from the request history.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{hcn_pkg::OP_READ,     8'd0,   1'b1, '{24'd0, 17'd0,    32'd0, 1'b1}},
        '{hcn_pkg::OP_CUMULATE, 8'd0,   1'b1, '{24'd0, 17'd0,    32'd0, 1'b1}},
        '{hcn_pkg::OP_COUNT,    8'd0,   1'b1, '{24'd0, 17'd0,    32'd1, 1'b0}},
        '{hcn_pkg::OP_READ,     8'd0,   1'b1, '{24'd1, hcn_pkg::ONE_Q16, 32'd1, 1'b0}},
        '{hcn_pkg::OP_COUNT,    8'd255, 1'b1, '{24'd0, 17'd0,    32'd2, 1'b0}},
        '{hcn_pkg::OP_READ,     8'd255, 1'b1, '{24'd1, 17'd32768, 32'd2, 1'b0}},
        '{hcn_pkg::OP_READ,     8'd128, 1'b1, '{24'd0, 17'd0,    32'd2, 1'b0}},
        '{hcn_pkg::OP_COUNT,    8'd170, 1'b0, '0},
        '{hcn_pkg::OP_COUNT,    8'd85,  1'b0, '0},
        '{hcn_pkg::OP_CUMULATE, 8'd0,   1'b0, '0},
        '{hcn_pkg::OP_READ,     8'd255, 1'b0, '0},
        '{hcn_pkg::OP_READ,     8'd85,  1'b0, '0},
        '{hcn_pkg::OP_CUMULATE, 8'd1,   1'b0, '0},
        '{hcn_pkg::OP_CUMULATE, 8'd2,   1'b0, '0},
        '{hcn_pkg::OP_CUMULATE, 8'd4,   1'b0, '0},
        '{hcn_pkg::OP_CUMULATE, 8'd8,   1'b0, '0},
        '{hcn_pkg::OP_CUMULATE, 8'd16,  1'b0, '0},
        '{hcn_pkg::OP_CUMULATE, 8'd32,  1'b0, '0},
        '{hcn_pkg::OP_CUMULATE, 8'd64,  1'b0, '0},
        '{hcn_pkg::OP_READ,     8'd255, 1'b0, '0},
        '{hcn_pkg::OP_COUNT,    8'd255, 1'b0, '0},
        '{hcn_pkg::OP_READ,     8'd0,   1'b0, '0},
        '{hcn_pkg::OP_CLEAR,    8'd255, 1'b1, '{24'd0, 17'd0,    32'd0, 1'b1}},
        '{hcn_pkg::OP_READ,     8'd255, 1'b1, '{24'd0, 17'd0,    32'd0, 1'b1}}
    };

    function automatic void clear_histogram();
        foreach (hist_bins[k]) hist_bins[k] = '0;
        hist_total = '0;
    endfunction

    // Apply one request to the shadow histogram and return the result it produces.
    function automatic t_hist_result update_histogram(hcn_pkg::t_op op,
                                                      logic [LEVEL_BITS-1:0] lvl);
        t_hist_result        res;
        logic [63:0]         acc;
        logic [63:0]         scaled;
        logic [COUNT_BITS:0] prefix;
        res = '0;
        case (op)
            hcn_pkg::OP_CLEAR: begin
                clear_histogram();
            end
            hcn_pkg::OP_COUNT: begin
                if (int'(lvl) < LEVELS && hist_bins[lvl] != hcn_pkg::BIN_MAX) begin
                    hist_bins[lvl] = hist_bins[lvl] + COUNT_BITS'(1);
                    if (hist_total != hcn_pkg::SUM_MAX)
                        hist_total = hist_total + SUM_BITS'(1);
                end
            end
            hcn_pkg::OP_CUMULATE: begin
                for (int k = 1; k < LEVELS; k++) begin
                    prefix = {1'b0, hist_bins[k]} + {1'b0, hist_bins[k-1]};
                    hist_bins[k] = prefix[COUNT_BITS] ? hcn_pkg::BIN_MAX
                                                      : prefix[COUNT_BITS-1:0];
                end
                acc = '0;
                for (int k = 0; k < LEVELS; k++) acc = acc + 64'(hist_bins[k]);
                hist_total = (acc > 64'(hcn_pkg::SUM_MAX)) ? hcn_pkg::SUM_MAX
                                                           : acc[SUM_BITS-1:0];
            end
            default: begin
                if (int'(lvl) < LEVELS) begin
                    res.bin_value = hist_bins[lvl];
                    if (hist_total != '0) begin
                        scaled = (64'(hist_bins[lvl]) << 16) / 64'(hist_total);
                        res.bin_fraction = (scaled > 64'(hcn_pkg::ONE_Q16))
                                           ? hcn_pkg::ONE_Q16 : scaled[FRAC_BITS-1:0];
                    end
                end
            end
        endcase
        res.total_sum  = hist_total;
        res.zero_total = (hist_total == '0);
        return res;
    endfunction

    task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Entered and left at a falling edge; valid stays high into the next request.
    task automatic issue_request(hcn_pkg::t_op op, logic [LEVEL_BITS-1:0] lvl,
                                 logic typed, t_hist_result want);
        t_hist_result predicted;
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.pixel_level <= lvl;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        predicted = update_histogram(op, lvl);
        expected_q.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic sender_gap();
        int span;
        span = $urandom_range(1, 16);
        req_if.valid <= 1'b0;
        repeat (span) @(negedge i_clk);
    endtask

    initial begin : request_driver
        hcn_pkg::t_op          op;
        logic [LEVEL_BITS-1:0] lvl;
        int                    pick;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.operation   = hcn_pkg::OP_CLEAR;
        req_if.pixel_level = '0;
        clear_histogram();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            if ($urandom_range(0, 3) == 0) sender_gap();
            issue_request(directed_rows[r].op, directed_rows[r].level,
                          directed_rows[r].typed, directed_rows[r].want);
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == HOLD_AT) hold_ready_low = 1'b1;
            if (n == QUIET_AT) quiet_tail = 1'b1;
            if (n == DRAIN_AT) begin
                // hold off until every pending result is out
                req_if.valid <= 1'b0;
                do @(negedge i_clk); while (expected_q.size() != 0);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                sender_gap();
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)       op = hcn_pkg::OP_CLEAR;
            else if (pick < 10) op = hcn_pkg::OP_CUMULATE;
            else if (pick < 70) op = hcn_pkg::OP_COUNT;
            else                op = hcn_pkg::OP_READ;
            // crowd a few low levels so their bins climb well past one
            if ($urandom_range(0, 2) == 0) lvl = LEVEL_BITS'($urandom_range(0, 7));
            else                           lvl = LEVEL_BITS'($urandom_range(0, 255));
            issue_request(op, lvl, 1'b0, '0);
        end

        req_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("[histogram_cumulative_normalize_unit] OK");
        else
            $display("[histogram_cumulative_normalize_unit] ERROR");
        $finish;
    end

    initial begin : result_acceptor
        int span;
        bit hold_done;
        hold_done    = 1'b0;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_ready_low && !hold_done) begin
                // long back-pressure: let the unit fill and stall its request side
                hold_done = 1'b1;
                rsp_if.ready <= 1'b0;
                span = LONG_HOLD;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                span = $urandom_range(1, 16);
            end else begin
                rsp_if.ready <= 1'b1;
                span = $urandom_range(1, 24);
            end
            repeat (span) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_hist_result want;
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (expected_q.size() == 0) begin
                flag_mismatch("result with no request pending",
                              64'(rsp_if.total_sum), 64'(0));
            end else begin
                want = expected_q.pop_front();
                if (rsp_if.bin_value !== want.bin_value)
                    flag_mismatch("bin_value", 64'(rsp_if.bin_value),
                                  64'(want.bin_value));
                if (rsp_if.bin_fraction !== want.bin_fraction)
                    flag_mismatch("bin_fraction", 64'(rsp_if.bin_fraction),
                                  64'(want.bin_fraction));
                if (rsp_if.total_sum !== want.total_sum)
                    flag_mismatch("total_sum", 64'(rsp_if.total_sum),
                                  64'(want.total_sum));
                if (rsp_if.zero_total !== want.zero_total)
                    flag_mismatch("zero_total", 64'(rsp_if.zero_total),
                                  64'(want.zero_total));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[histogram_cumulative_normalize_unit] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
